FILE: sv/four_function_calculator_core_unit_defines.svh
// Assertion macros shared by the calculator core checker.
// No dependencies; pulled in by ffc_checker.sv.
`ifndef FOUR_FUNCTION_CALCULATOR_CORE_UNIT_DEFINES_SVH
`define FOUR_FUNCTION_CALCULATOR_CORE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define FFC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define FFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ffc_pkg.sv
// Types, codes and microcode ROM of the calculator core.
// No dependencies; used by four_function_calculator_core_unit and ffc_checker.
`default_nettype none

package ffc_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DATA_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

  // key opcodes
  localparam logic [2:0] OPC_DIGIT      = 3'd0;
  localparam logic [2:0] OPC_OPERATOR   = 3'd1;
  localparam logic [2:0] OPC_EQUALS     = 3'd2;
  localparam logic [2:0] OPC_MEM_ADD    = 3'd3;
  localparam logic [2:0] OPC_MEM_CLEAR  = 3'd4;
  localparam logic [2:0] OPC_MEM_RECALL = 3'd5;
  localparam logic [2:0] OPC_ALL_CLEAR  = 3'd6;

  // pending operator codes
  localparam logic [2:0] OPR_NONE = 3'd0;
  localparam logic [2:0] OPR_ADD  = 3'd1;
  localparam logic [2:0] OPR_SUB  = 3'd2;
  localparam logic [2:0] OPR_MUL  = 3'd3;
  localparam logic [2:0] OPR_DIV  = 3'd4;

  localparam logic [3:0] MAX_DIGIT = 4'd9;

  typedef struct packed {
    logic [2:0] opcode;
    logic [3:0] digit_value;
    logic [2:0] operator_code;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] display_value;
    logic signed [DATA_W-1:0] memory_value;
    logic signed [DATA_W-1:0] accumulator_value;
    logic                     error_flag;
  } out_item_t;

  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  // datapath action of one microstep
  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_DIGIT,
    ACT_MEM_ADD,
    ACT_MEM_CLEAR,
    ACT_MEM_RECALL,
    ACT_ALL_CLEAR,
    ACT_EVAL,
    ACT_DIV_INIT,
    ACT_DIV_STEP,
    ACT_DIV_FIX,
    ACT_OPER_POST,
    ACT_EQ_POST,
    ACT_EMIT
  } act_t;

  // sequencing of one microstep
  typedef enum logic [2:0] {
    BR_NEXT,
    BR_JUMP,
    BR_IF_DIV,
    BR_IF_EQ,
    BR_IF_ZERO,
    BR_LOOP,
    BR_EMIT
  } br_t;

  typedef struct packed {
    act_t act;
    br_t  br;
    upc_t target;
  } ctrl_word_t;

  // microcode addresses
  localparam upc_t UPC_DIGIT    = 4'd0;
  localparam upc_t UPC_MADD     = 4'd1;
  localparam upc_t UPC_MCLR     = 4'd2;
  localparam upc_t UPC_MRCL     = 4'd3;
  localparam upc_t UPC_ACLR     = 4'd4;
  localparam upc_t UPC_EVAL     = 4'd5;
  localparam upc_t UPC_POST     = 4'd6;
  localparam upc_t UPC_OPER_END = 4'd7;
  localparam upc_t UPC_DIV_INIT = 4'd8;
  localparam upc_t UPC_DIV_STEP = 4'd9;
  localparam upc_t UPC_DIV_FIX  = 4'd10;
  localparam upc_t UPC_EQ_END   = 4'd11;
  localparam upc_t UPC_EMIT     = 4'd12;

  function automatic ctrl_word_t ucode_rom(input upc_t upc);
    ctrl_word_t cw;
    case (upc)
      UPC_DIGIT:    cw = '{ACT_DIGIT,      BR_JUMP,    UPC_EMIT};
      UPC_MADD:     cw = '{ACT_MEM_ADD,    BR_JUMP,    UPC_EMIT};
      UPC_MCLR:     cw = '{ACT_MEM_CLEAR,  BR_JUMP,    UPC_EMIT};
      UPC_MRCL:     cw = '{ACT_MEM_RECALL, BR_JUMP,    UPC_EMIT};
      UPC_ACLR:     cw = '{ACT_ALL_CLEAR,  BR_JUMP,    UPC_EMIT};
      UPC_EVAL:     cw = '{ACT_EVAL,       BR_IF_DIV,  UPC_DIV_INIT};
      UPC_POST:     cw = '{ACT_NOP,        BR_IF_EQ,   UPC_EQ_END};
      UPC_OPER_END: cw = '{ACT_OPER_POST,  BR_JUMP,    UPC_EMIT};
      UPC_DIV_INIT: cw = '{ACT_DIV_INIT,   BR_IF_ZERO, UPC_POST};
      UPC_DIV_STEP: cw = '{ACT_DIV_STEP,   BR_LOOP,    UPC_DIV_STEP};
      UPC_DIV_FIX:  cw = '{ACT_DIV_FIX,    BR_JUMP,    UPC_POST};
      UPC_EQ_END:   cw = '{ACT_EQ_POST,    BR_JUMP,    UPC_EMIT};
      UPC_EMIT:     cw = '{ACT_EMIT,       BR_EMIT,    UPC_EMIT};
      default:      cw = '{ACT_NOP,        BR_JUMP,    UPC_EMIT};
    endcase
    return cw;
  endfunction

  // first microstep for each key opcode; unused opcodes just report state
  function automatic upc_t entry_of(input logic [2:0] opc);
    upc_t upc;
    case (opc)
      OPC_DIGIT:      upc = UPC_DIGIT;
      OPC_OPERATOR:   upc = UPC_EVAL;
      OPC_EQUALS:     upc = UPC_EVAL;
      OPC_MEM_ADD:    upc = UPC_MADD;
      OPC_MEM_CLEAR:  upc = UPC_MCLR;
      OPC_MEM_RECALL: upc = UPC_MRCL;
      OPC_ALL_CLEAR:  upc = UPC_ACLR;
      default:        upc = UPC_EMIT;
    endcase
    return upc;
  endfunction

endpackage

`default_nettype wire

FILE: sv/four_function_calculator_core_unit.sv
// Top level of the four-function calculator core: sequencer and datapath.
// Depends on ffc_pkg.
`default_nettype none

// Four-function calculator with one memory register. Each key event taken on
// the in_ channel produces exactly one result transfer on the out_ channel
// carrying display, memory, accumulator and the divide-by-zero flag after that
// key. Control is a 13-word microcode ROM (ffc_pkg::ucode_rom) stepped by a
// micro-PC with conditional jumps; the datapath holds the calculator registers
// and a restoring divider that retires one quotient bit per step. Steps per
// key: digits, memory keys and all clear run their action step, then the
// emit step; unused opcodes go straight to the emit step; operator/equals
// with add, sub, mul or no operator run evaluate, post and the operator or
// equals end step, then emit; a divide runs init, the divider loop (one step
// per bit of the data width), fix, post, end and emit; a divide by zero goes
// from init straight to post. in_stall is high while a key is in the
// sequencer. A finished result sits in an output register, and the next
// key is taken while it waits; a key reaching its final step while the
// previous result is still stalled holds there until the output frees up.
// All arithmetic wraps in two's complement; most negative / -1 wraps.
module four_function_calculator_core_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire ffc_pkg::in_item_t in_data,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      ffc_pkg::out_item_t out_data
);

  localparam int DW = ffc_pkg::DATA_W;

  // sequencer
  logic                busy_r, busy_nxt;
  ffc_pkg::upc_t       upc_r, upc_nxt;
  ffc_pkg::in_item_t   item_r, item_nxt;
  ffc_pkg::ctrl_word_t cw;

  // calculator registers
  logic [DW-1:0] disp_r, disp_nxt;
  logic [DW-1:0] acc_r, acc_nxt;
  logic [DW-1:0] mem_r, mem_nxt;
  logic [2:0]    pend_r, pend_nxt;
  logic          err_r, err_nxt;

  // divider
  logic [DW-1:0]             rem_r, rem_nxt;
  logic [DW-1:0]             quo_r, quo_nxt;
  logic [DW-1:0]             dvs_r, dvs_nxt;
  logic                      neg_r, neg_nxt;
  logic [ffc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  ffc_pkg::out_item_t out_data_r, out_data_nxt;

  logic          in_xfer;
  logic          out_free;
  logic [DW-1:0] disp_x10;
  logic [DW-1:0] prod_lo;
  logic [DW-1:0] acc_mag;
  logic [DW-1:0] disp_mag;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  assign in_stall  = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_xfer  = in_valid && !busy_r;
  // output slot is free when empty or its result leaves this cycle
  assign out_free = !out_valid_r || !out_stall;

  assign cw = ffc_pkg::ucode_rom(upc_r);

  // datapath operators
  assign disp_x10 = (disp_r << 3) + (disp_r << 1);
  assign prod_lo  = acc_r * disp_r;
  assign acc_mag  = acc_r[DW-1] ? (DW'(0) - acc_r) : acc_r;
  assign disp_mag = disp_r[DW-1] ? (DW'(0) - disp_r) : disp_r;
  // restoring divide step: shift in next dividend bit, try to subtract
  assign trial    = {rem_r, quo_r[DW-1]};
  assign diff     = trial - {1'b0, dvs_r};
  assign fits     = !diff[DW];

  always_comb begin
    busy_nxt      = busy_r;
    upc_nxt       = upc_r;
    item_nxt      = item_r;
    disp_nxt      = disp_r;
    acc_nxt       = acc_r;
    mem_nxt       = mem_r;
    pend_nxt      = pend_r;
    err_nxt       = err_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dvs_nxt       = dvs_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    if (in_xfer) begin
      busy_nxt = 1'b1;
      upc_nxt  = ffc_pkg::entry_of(in_data.opcode);
      item_nxt = in_data;
    end else if (busy_r) begin
      case (cw.act)
        ffc_pkg::ACT_NOP: begin
        end
        ffc_pkg::ACT_DIGIT: begin
          if (item_r.digit_value <= ffc_pkg::MAX_DIGIT) begin
            disp_nxt = disp_x10 + DW'(item_r.digit_value);
          end
        end
        ffc_pkg::ACT_MEM_ADD:    mem_nxt  = mem_r + disp_r;
        ffc_pkg::ACT_MEM_CLEAR:  mem_nxt  = '0;
        ffc_pkg::ACT_MEM_RECALL: disp_nxt = mem_r;
        ffc_pkg::ACT_ALL_CLEAR: begin
          disp_nxt = '0;
          acc_nxt  = '0;
          mem_nxt  = '0;
          pend_nxt = ffc_pkg::OPR_NONE;
          err_nxt  = 1'b0;
        end
        ffc_pkg::ACT_EVAL: begin
          // divide goes to the divider microsteps; unknown codes change nothing
          case (pend_r)
            ffc_pkg::OPR_NONE: begin
              acc_nxt = disp_r;
              err_nxt = 1'b0;
            end
            ffc_pkg::OPR_ADD: begin
              acc_nxt = acc_r + disp_r;
              err_nxt = 1'b0;
            end
            ffc_pkg::OPR_SUB: begin
              acc_nxt = acc_r - disp_r;
              err_nxt = 1'b0;
            end
            ffc_pkg::OPR_MUL: begin
              acc_nxt = prod_lo;
              err_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
        ffc_pkg::ACT_DIV_INIT: begin
          if (disp_r == '0) begin
            acc_nxt = '0;
            err_nxt = 1'b1;
          end else begin
            rem_nxt = '0;
            quo_nxt = acc_mag;
            dvs_nxt = disp_mag;
            neg_nxt = acc_r[DW-1] ^ disp_r[DW-1];
            cnt_nxt = '0;
          end
        end
        ffc_pkg::ACT_DIV_STEP: begin
          rem_nxt = fits ? diff[DW-1:0] : trial[DW-1:0];
          quo_nxt = {quo_r[DW-2:0], fits};
          cnt_nxt = cnt_r + 1'b1;
        end
        ffc_pkg::ACT_DIV_FIX: begin
          acc_nxt = neg_r ? (DW'(0) - quo_r) : quo_r;
          err_nxt = 1'b0;
        end
        ffc_pkg::ACT_OPER_POST: begin
          disp_nxt = '0;
          pend_nxt = item_r.operator_code;
        end
        ffc_pkg::ACT_EQ_POST: begin
          disp_nxt = acc_r;
          pend_nxt = ffc_pkg::OPR_NONE;
        end
        ffc_pkg::ACT_EMIT: begin
          if (out_free) begin
            out_valid_nxt                  = 1'b1;
            out_data_nxt.display_value     = disp_r;
            out_data_nxt.memory_value      = mem_r;
            out_data_nxt.accumulator_value = acc_r;
            out_data_nxt.error_flag        = err_r;
          end
        end
        default: begin
        end
      endcase

      case (cw.br)
        ffc_pkg::BR_NEXT: upc_nxt = upc_r + 1'b1;
        ffc_pkg::BR_JUMP: upc_nxt = cw.target;
        ffc_pkg::BR_IF_DIV: begin
          upc_nxt = (pend_r == ffc_pkg::OPR_DIV) ? cw.target : upc_r + 1'b1;
        end
        ffc_pkg::BR_IF_EQ: begin
          upc_nxt = (item_r.opcode == ffc_pkg::OPC_EQUALS) ? cw.target : upc_r + 1'b1;
        end
        ffc_pkg::BR_IF_ZERO: begin
          upc_nxt = (disp_r == '0) ? cw.target : upc_r + 1'b1;
        end
        ffc_pkg::BR_LOOP: begin
          upc_nxt = (cnt_r != ffc_pkg::CNT_LAST) ? cw.target : upc_r + 1'b1;
        end
        ffc_pkg::BR_EMIT: begin
          // hold here until the result is loaded, then release the input
          if (out_free) begin
            busy_nxt = 1'b0;
          end
        end
        default: upc_nxt = ffc_pkg::UPC_EMIT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      upc_r       <= ffc_pkg::UPC_EMIT;
      out_valid_r <= 1'b0;
      disp_r      <= '0;
      acc_r       <= '0;
      mem_r       <= '0;
      pend_r      <= ffc_pkg::OPR_NONE;
      err_r       <= 1'b0;
      cnt_r       <= '0;
    end else begin
      busy_r      <= busy_nxt;
      upc_r       <= upc_nxt;
      out_valid_r <= out_valid_nxt;
      disp_r      <= disp_nxt;
      acc_r       <= acc_nxt;
      mem_r       <= mem_nxt;
      pend_r      <= pend_nxt;
      err_r       <= err_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    dvs_r      <= dvs_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

FILE: sv/ffc_checker.sv
// Port-level assertion checker for the calculator core, bound to the top level.
// Depends on ffc_pkg and four_function_calculator_core_unit_defines.svh.
`default_nettype none

`include "four_function_calculator_core_unit_defines.svh"

module ffc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire ffc_pkg::out_item_t out_data
);

  // a stalled result holds
  `FFC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // one key at a time: input closes right after a transfer
  `FFC_ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, in_valid && !in_stall, in_stall, "input open right after a key transfer")

  // a new result only appears while a key is in the sequencer
  `FFC_ASSERT_SAME(a_result_from_key, clk, rst_n, $rose(out_valid), $past(in_stall), "result without a key in progress")

  // a result with the error flag set carries a zero accumulator; only divide by zero sets the flag
  `FFC_ASSERT_SAME(a_err_zero_acc, clk, rst_n, out_valid && out_data.error_flag, out_data.accumulator_value == '0, "error flag with nonzero accumulator")

endmodule

bind four_function_calculator_core_unit ffc_checker u_ffc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

FILE: test/tb_four_function_calculator_core_unit.sv
// Testbench for four_function_calculator_core_unit. It sends a short directed
// key sequence and then random key sequences, and checks each result against
// its own model. Depends on ffc_pkg and the calculator core RTL.
`timescale 1ns / 1ps

module tb_four_function_calculator_core_unit;

  localparam int DATA_W = ffc_pkg::DATA_W;

  // Codes that the package leaves unnamed: the unused key opcode, and the
  // operator codes past divide. A spare operator code is stored as pending,
  // and evaluating it changes nothing.
  localparam logic [2:0] OPC_UNUSED   = 3'd7;
  localparam logic [2:0] OPR_SPARE_LO = 3'd5;
  localparam logic [2:0] OPR_SPARE_HI = 3'd7;

  localparam int RANDOM_KEYS   = 1550;
  localparam int IDLE_PCT      = 18;
  // keys / results counted between these marks see no gaps and no stalls
  localparam int CALM_FROM     = 600;
  localparam int CALM_TO       = 900;
  // settle time after draining, longer than a divide takes, enough to flush
  localparam int SETTLE_CYCLES = 60;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  ffc_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ffc_pkg::out_item_t out_data;

  four_function_calculator_core_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Keys waiting to be sent, and readouts predicted for keys already taken.
  ffc_pkg::in_item_t  key_queue[$];
  ffc_pkg::out_item_t readout_q[$];

  int keys_planned = 0;   // keys queued that the core acts on
  int keys_done = 0;      // input transfers
  int results_done = 0;   // output transfers
  int mismatches = 0;
  logic key_taken = 1'b0; // input transfer at the last rising edge

  // Calculator state as the core should hold it.
  logic [DATA_W-1:0] calc_display = '0;
  logic [DATA_W-1:0] calc_accum = '0;
  logic [DATA_W-1:0] calc_memory = '0;
  logic [2:0]        calc_pending = ffc_pkg::OPR_NONE;
  logic              calc_err = 1'b0;

  // Apply the pending operator to accumulator and display. Divide truncates
  // toward zero on magnitudes; the most negative value over -1 wraps back to
  // itself since its magnitude is 2^(DATA_W-1) as an unsigned word.
  function automatic void calc_evaluate();
    logic [DATA_W-1:0] mag_a, mag_d, quo;
    case (calc_pending)
      ffc_pkg::OPR_NONE: begin
        calc_accum = calc_display;
        calc_err = 1'b0;
      end
      ffc_pkg::OPR_ADD: begin
        calc_accum = calc_accum + calc_display;
        calc_err = 1'b0;
      end
      ffc_pkg::OPR_SUB: begin
        calc_accum = calc_accum - calc_display;
        calc_err = 1'b0;
      end
      ffc_pkg::OPR_MUL: begin
        calc_accum = calc_accum * calc_display;
        calc_err = 1'b0;
      end
      ffc_pkg::OPR_DIV: begin
        if (calc_display == '0) begin
          calc_accum = '0;
          calc_err = 1'b1;
        end else begin
          mag_a = calc_accum[DATA_W-1] ? -calc_accum : calc_accum;
          mag_d = calc_display[DATA_W-1] ? -calc_display : calc_display;
          quo = mag_a / mag_d;
          if (calc_accum[DATA_W-1] != calc_display[DATA_W-1]) quo = -quo;
          calc_accum = quo;
          calc_err = 1'b0;
        end
      end
      default: ; // spare operator codes leave accumulator and error alone
    endcase
  endfunction

  // One key press: update the state and return the readout after it.
  function automatic ffc_pkg::out_item_t calc_key_press(ffc_pkg::in_item_t key);
    ffc_pkg::out_item_t readout;
    case (key.opcode)
      ffc_pkg::OPC_DIGIT: begin
        if (key.digit_value <= ffc_pkg::MAX_DIGIT)
          calc_display = calc_display * DATA_W'(10) + DATA_W'(key.digit_value);
      end
      ffc_pkg::OPC_OPERATOR: begin
        calc_evaluate();
        calc_display = '0;
        calc_pending = key.operator_code;
      end
      ffc_pkg::OPC_EQUALS: begin
        calc_evaluate();
        calc_pending = ffc_pkg::OPR_NONE;
        calc_display = calc_accum;
      end
      ffc_pkg::OPC_MEM_ADD:    calc_memory = calc_memory + calc_display;
      ffc_pkg::OPC_MEM_CLEAR:  calc_memory = '0;
      ffc_pkg::OPC_MEM_RECALL: calc_display = calc_memory;
      ffc_pkg::OPC_ALL_CLEAR: begin
        calc_display = '0;
        calc_accum = '0;
        calc_memory = '0;
        calc_pending = ffc_pkg::OPR_NONE;
        calc_err = 1'b0;
      end
      default: ; // unused opcode only reports the state
    endcase
    readout.display_value = calc_display;
    readout.memory_value = calc_memory;
    readout.accumulator_value = calc_accum;
    readout.error_flag = calc_err;
    return readout;
  endfunction

  function automatic void push_key(logic [2:0] opc, logic [3:0] dig, logic [2:0] opr);
    ffc_pkg::in_item_t key;
    key.opcode = opc;
    key.digit_value = dig;
    key.operator_code = opr;
    key_queue.push_back(key);
    // keys the core ignores do not count toward the random total
    if (opc != OPC_UNUSED && !(opc == ffc_pkg::OPC_DIGIT && dig > ffc_pkg::MAX_DIGIT))
      keys_planned++;
  endfunction

  // Mostly short numbers, now and then none at all (a zero operand, which
  // makes divide by zero likely) or long ones that can overflow the display.
  function automatic void push_digits();
    int pick, count;
    pick = $urandom_range(19);
    if (pick == 0) count = 0;
    else if (pick == 1) count = $urandom_range(8, 11);
    else count = $urandom_range(1, 3);
    for (int i = 0; i < count; i++)
      push_key(ffc_pkg::OPC_DIGIT, 4'($urandom_range(ffc_pkg::MAX_DIGIT)),
               3'($urandom_range(7)));
  endfunction

  function automatic logic [2:0] pick_operator();
    int pick;
    pick = $urandom_range(99);
    if (pick < 88) return 3'($urandom_range(ffc_pkg::OPR_ADD, ffc_pkg::OPR_DIV));
    if (pick < 92) return ffc_pkg::OPR_NONE;
    return 3'($urandom_range(OPR_SPARE_LO, OPR_SPARE_HI));
  endfunction

  // Random key sequences: mostly whole expressions (number, operator, number,
  // maybe more operators, usually equals), with memory keys, all clear and
  // fully random noise keys mixed in.
  task automatic queue_random_keys(int upto);
    int pick, chain;
    while (keys_planned < upto) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        push_digits();
        push_key(ffc_pkg::OPC_OPERATOR, 4'($urandom_range(15)), pick_operator());
        push_digits();
        chain = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
        for (int i = 0; i < chain; i++) begin
          push_key(ffc_pkg::OPC_OPERATOR, 4'($urandom_range(15)), pick_operator());
          push_digits();
        end
        if ($urandom_range(4) != 0)
          push_key(ffc_pkg::OPC_EQUALS, 4'($urandom_range(15)), 3'($urandom_range(7)));
      end else if (pick < 86) begin
        push_key(3'($urandom_range(ffc_pkg::OPC_MEM_ADD, ffc_pkg::OPC_MEM_RECALL)),
                 4'($urandom_range(15)), 3'($urandom_range(7)));
      end else if (pick < 89) begin
        push_key(ffc_pkg::OPC_ALL_CLEAR, 4'($urandom_range(15)), 3'($urandom_range(7)));
      end else begin
        push_key(3'($urandom_range(7)), 4'($urandom_range(15)), 3'($urandom_range(7)));
      end
    end
  endtask

  // Hold the sender until every queued key is sent and every readout is in.
  task automatic wait_drained();
    while (key_queue.size() != 0 || in_valid || readout_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic check_field(string what, logic [DATA_W-1:0] want,
                             logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d",
               $time, what, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  // Sender: drives at the falling edge. A new key goes out only once the
  // previous one has transferred, so a stalled key holds steady. Gaps come in
  // at random except in the calm window.
  always @(negedge clk) begin
    logic gap;
    gap = !(keys_done >= CALM_FROM && keys_done < CALM_TO) &&
          $urandom_range(99) < IDLE_PCT;
    if (rst_n && (!in_valid || key_taken)) begin
      if (key_queue.size() != 0 && !gap) begin
        in_valid <= 1'b1;
        in_data <= key_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, random except in the calm window.
  always @(negedge clk) begin
    out_stall <= !(results_done >= CALM_FROM && results_done < CALM_TO) &&
                 $urandom_range(99) < IDLE_PCT;
  end

  // Monitor: at each rising edge, predict on an input transfer and check an
  // output transfer against the oldest prediction.
  always @(posedge clk) begin
    ffc_pkg::out_item_t want;
    key_taken = rst_n && in_valid && !in_stall;
    if (key_taken) begin
      readout_q.push_back(calc_key_press(in_data));
      keys_done++;
    end
    if (rst_n && out_valid && !out_stall) begin
      results_done++;
      if (readout_q.size() == 0) begin
        $display("%0t: result with nothing expected: display %0d memory %0d acc %0d err %0b",
                 $time, out_data.display_value, out_data.memory_value,
                 out_data.accumulator_value, out_data.error_flag);
        mismatches++;
      end else begin
        want = readout_q.pop_front();
        check_field("display", want.display_value, out_data.display_value);
        check_field("memory", want.memory_value, out_data.memory_value);
        check_field("accumulator", want.accumulator_value, out_data.accumulator_value);
        check_field("error", DATA_W'(want.error_flag), DATA_W'(out_data.error_flag));
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int min_digits[10] = '{2, 1, 4, 7, 4, 8, 3, 6, 4, 8};

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: build -1 into memory, ignored digits above nine, type
    // 2147483648 so the display overflows to the most negative value,
    // divide it by -1, divide by zero, memory keys with the error set,
    // a spare operator code, multiply, the unused opcode, all clear.
    push_key(ffc_pkg::OPC_ALL_CLEAR, 4'd0, 3'd0);
    push_key(ffc_pkg::OPC_OPERATOR, 4'd0, ffc_pkg::OPR_SUB);
    push_key(ffc_pkg::OPC_DIGIT, 4'd1, 3'd0);
    push_key(ffc_pkg::OPC_EQUALS, 4'd0, 3'd0);
    push_key(ffc_pkg::OPC_MEM_ADD, 4'd0, 3'd0);
    push_key(ffc_pkg::OPC_DIGIT, 4'hF, 3'h7);
    push_key(ffc_pkg::OPC_DIGIT, 4'hA, 3'd0);
    push_key(ffc_pkg::OPC_OPERATOR, 4'd0, ffc_pkg::OPR_NONE);
    foreach (min_digits[i]) push_key(ffc_pkg::OPC_DIGIT, 4'(min_digits[i]), 3'd0);
    push_key(ffc_pkg::OPC_OPERATOR, 4'd0, ffc_pkg::OPR_DIV);
    push_key(ffc_pkg::OPC_MEM_RECALL, 4'd0, 3'd0);
    push_key(ffc_pkg::OPC_EQUALS, 4'd0, 3'd0);
    push_key(ffc_pkg::OPC_OPERATOR, 4'd0, ffc_pkg::OPR_DIV);
    push_key(ffc_pkg::OPC_EQUALS, 4'd0, 3'd0);
    push_key(ffc_pkg::OPC_MEM_ADD, 4'd0, 3'd0);
    push_key(ffc_pkg::OPC_MEM_CLEAR, 4'd0, 3'd0);
    push_key(ffc_pkg::OPC_OPERATOR, 4'd0, OPR_SPARE_LO);
    push_key(ffc_pkg::OPC_DIGIT, 4'd3, 3'd0);
    push_key(ffc_pkg::OPC_OPERATOR, 4'd0, ffc_pkg::OPR_MUL);
    push_key(ffc_pkg::OPC_DIGIT, 4'd7, 3'd0);
    push_key(ffc_pkg::OPC_EQUALS, 4'd0, 3'd0);
    push_key(OPC_UNUSED, 4'hF, 3'h7);
    push_key(ffc_pkg::OPC_MEM_ADD, 4'd0, 3'd0);
    push_key(ffc_pkg::OPC_ALL_CLEAR, 4'd0, 3'd0);
    wait_drained();

    // random keys in two halves; the sender drains fully in between
    keys_planned = 0;
    queue_random_keys(RANDOM_KEYS / 2);
    wait_drained();
    queue_random_keys(RANDOM_KEYS);
    wait_drained();

    // let a stray late result show up before judging
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && readout_q.size() == 0) begin
      $display("PASS four_function_calculator_core_unit");
    end else begin
      $display("FAIL four_function_calculator_core_unit");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (every key a divide with
  // heavy stalls on both sides).
  initial begin
    #10_000_000;
    $display("FAIL four_function_calculator_core_unit");
    $finish;
  end

endmodule
